@@ rtl/core/movie_header_box_parser_defines.svh @@
// Assertion macros for the movie header box parser.
// No dependencies; included by files that carry concurrent checks.
`ifndef MOVIE_HEADER_BOX_PARSER_DEFINES_SVH
`define MOVIE_HEADER_BOX_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// expr must hold at every edge out of reset
`define MHBP_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("mhbp assertion failed");
// ante implies cons in the same cycle
`define MHBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mhbp implication failed");
`else
`define MHBP_ASSERT(label, clk, rst_n, expr)
`define MHBP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/mhbp_pkg.sv @@
// Shared types, codes and field lookup for the movie header box parser.
// No dependencies.
package mhbp_pkg;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 7;
    localparam int FID_W    = 5;
    localparam int VALUE_W  = 64;

    localparam int RESERVED32_COUNT = 2;
    localparam int MATRIX_COUNT     = 9;
    localparam int PREDEF_COUNT     = 6;

    localparam logic [BYTE_W-1:0] LONG_VERSION_CODE = 8'd1;

    // field ids
    localparam logic [FID_W-1:0] FID_VERSION    = 5'd0;
    localparam logic [FID_W-1:0] FID_FLAGS      = 5'd1;
    localparam logic [FID_W-1:0] FID_CTIME      = 5'd2;
    localparam logic [FID_W-1:0] FID_MTIME      = 5'd3;
    localparam logic [FID_W-1:0] FID_TIMESCALE  = 5'd4;
    localparam logic [FID_W-1:0] FID_DURATION   = 5'd5;
    localparam logic [FID_W-1:0] FID_RATE       = 5'd6;
    localparam logic [FID_W-1:0] FID_VOLUME     = 5'd7;
    localparam logic [FID_W-1:0] FID_RESERVED16 = 5'd8;
    localparam logic [FID_W-1:0] FID_RSVD32_0   = 5'd9;
    localparam logic [FID_W-1:0] FID_MATRIX_0   = FID_RSVD32_0 + 5'(RESERVED32_COUNT);
    localparam logic [FID_W-1:0] FID_PREDEF_0   = FID_MATRIX_0 + 5'(MATRIX_COUNT);
    localparam logic [FID_W-1:0] FID_NEXT_TRACK = FID_PREDEF_0 + 5'(PREDEF_COUNT);

    typedef enum logic [1:0] {
        ST_OK              = 2'd0,
        ST_RSVD_NONZERO    = 2'd1,
        ST_NEXT_TRACK_ZERO = 2'd2,
        ST_TRUNCATED       = 2'd3
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_box;
    } t_in_item;

    // input stage -> field engine
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_stage_out;

    typedef struct packed {
        logic             hit;   // position lies inside the field map
        logic [FID_W-1:0] id;
        logic             last;  // final byte of that field
    } t_loc;

    // Maps a payload byte position to its field; time fields are 8 or 4 bytes.
    function automatic t_loc f_locate(logic [POS_W-1:0] pos, logic lv);
        logic [POS_W-1:0] t1;
        logic [POS_W-1:0] t2;
        logic [POS_W-1:0] t3;
        logic [POS_W-1:0] rel;
        t_loc             loc;
        t1  = lv ? 7'd8  : 7'd4;
        t2  = lv ? 7'd16 : 7'd8;
        t3  = lv ? 7'd24 : 7'd12;
        rel = pos - (7'd16 + t3);
        loc = '{hit: 1'b1, id: FID_VERSION, last: 1'b0};
        if (pos == 7'd0) begin
            loc.id = FID_VERSION;    loc.last = 1'b1;
        end else if (pos < 7'd4) begin
            loc.id = FID_FLAGS;      loc.last = (pos == 7'd3);
        end else if (pos < 7'd4 + t1) begin
            loc.id = FID_CTIME;      loc.last = (pos == 7'd3 + t1);
        end else if (pos < 7'd4 + t2) begin
            loc.id = FID_MTIME;      loc.last = (pos == 7'd3 + t2);
        end else if (pos < 7'd8 + t2) begin
            loc.id = FID_TIMESCALE;  loc.last = (pos == 7'd7 + t2);
        end else if (pos < 7'd8 + t3) begin
            loc.id = FID_DURATION;   loc.last = (pos == 7'd7 + t3);
        end else if (pos < 7'd12 + t3) begin
            loc.id = FID_RATE;       loc.last = (pos == 7'd11 + t3);
        end else if (pos < 7'd14 + t3) begin
            loc.id = FID_VOLUME;     loc.last = (pos == 7'd13 + t3);
        end else if (pos < 7'd16 + t3) begin
            loc.id = FID_RESERVED16; loc.last = (pos == 7'd15 + t3);
        end else if (pos < 7'd88 + t3) begin
            // run of 4-byte words: reserved, matrix, predefined, next track
            loc.id   = FID_RSVD32_0 + rel[6:2];
            loc.last = (rel[1:0] == 2'b11);
        end else begin
            loc.hit  = 1'b0;
        end
        return loc;
    endfunction

    function automatic logic f_is_reserved(logic [FID_W-1:0] id);
        return ((id >= FID_RESERVED16) && (id < FID_MATRIX_0)) ||
               ((id >= FID_PREDEF_0) && (id < FID_NEXT_TRACK));
    endfunction

endpackage

@@ rtl/core/mhbp_stream_if.sv @@
// Valid/ready channel interfaces for the byte input and the field output.
// Depends on mhbp_pkg.
interface mhbp_in_if import mhbp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_box;

    modport source (output valid, output data_byte, output end_of_box, input ready);
    modport sink   (input valid, input data_byte, input end_of_box, output ready);
endinterface

interface mhbp_out_if import mhbp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FID_W-1:0]   field_id;
    logic [VALUE_W-1:0] field_value;
    t_status            status;
    logic               box_done;

    modport source (output valid, output field_id, output field_value, output status,
                    output box_done, input ready);
    modport sink   (input valid, input field_id, input field_value, input status,
                    input box_done, output ready);
endinterface

@@ rtl/core/movie_header_box_parser.sv @@
// Top level of the movie header (mvhd) box payload parser.
// Depends on mhbp_pkg, mhbp_stream_if, mhbp_in_stage, mhbp_field_engine.
//
// Use:
//  - i_in carries the box payload one byte per transfer, starting with the
//    version byte; end_of_box marks the last byte available for the box.
//  - o_out carries one transfer per finished field: field_id, the big-endian
//    value zero extended to 64 bits, a status code and box_done.
//  - Version 1 boxes carry 64-bit times and duration (112 payload bytes),
//    any other version 32-bit ones (100 bytes). Bytes after the next track
//    id are dropped up to end_of_box; a short box ends with a truncated
//    result holding the partial field value.
//  - Throughput: one byte per cycle while o_out takes each result; a result
//    that is not taken stalls the engine. A field's last byte passes through
//    the input register, then the result register presents the field.
//  - Stall: while o_out holds a result that is not taken, the engine keeps
//    its byte and i_in takes at most one more byte into the input register.
//  - Reset (i_rst_n low, synchronous) empties both registers and returns the
//    parser to the version byte of a new box.
`include "movie_header_box_parser_defines.svh"
module movie_header_box_parser
    import mhbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mhbp_in_if.sink    i_in,
    mhbp_out_if.source o_out
);

    t_stage_out w_stage;
    logic       w_take;

    // byte input register
    mhbp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_stage (w_stage)
    );

    // field decode, assembly and result register
    mhbp_field_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_stage),
        .o_take  (w_take),
        .o_out   (o_out)
    );

    // a finished box is either truncated or closed by the next track id
    `MHBP_ASSERT_IMP(a_done_cause, i_clk, i_rst_n, o_out.valid && o_out.box_done, (o_out.status == ST_TRUNCATED) || (o_out.field_id == FID_NEXT_TRACK))
    // truncation always ends the box
    `MHBP_ASSERT_IMP(a_trunc_done, i_clk, i_rst_n, o_out.valid && (o_out.status == ST_TRUNCATED), o_out.box_done)
    // zero next track flag only on that field with a zero value
    `MHBP_ASSERT_IMP(a_ntz_value, i_clk, i_rst_n, o_out.valid && (o_out.status == ST_NEXT_TRACK_ZERO), (o_out.field_id == FID_NEXT_TRACK) && (o_out.field_value == '0))
    // reserved flag only on reserved or predefined words
    `MHBP_ASSERT_IMP(a_rsvd_id, i_clk, i_rst_n, o_out.valid && (o_out.status == ST_RSVD_NONZERO), f_is_reserved(o_out.field_id))

endmodule

@@ rtl/core/mhbp_in_stage.sv @@
// Input register of the parser: captures one byte transfer per cycle while it is empty or its byte is taken.
// Depends on mhbp_pkg and mhbp_in_if.
module mhbp_in_stage
    import mhbp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    mhbp_in_if.sink       i_in,
    input  logic          i_take,
    output t_stage_out    o_stage
);

    logic     r_valid;
    t_in_item r_item;
    logic     w_load;

    assign i_in.ready = !r_valid || i_take;
    assign w_load     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.data_byte  <= i_in.data_byte;
            r_item.end_of_box <= i_in.end_of_box;
        end
    end

    assign o_stage = '{valid: r_valid, item: r_item};

endmodule

@@ rtl/core/mhbp_field_engine.sv @@
// Parse state, field assembly and the result register.
// Depends on mhbp_pkg and mhbp_out_if.
module mhbp_field_engine
    import mhbp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_stage_out    i_stage,
    output logic          o_take,
    mhbp_out_if.source    o_out
);

    logic [POS_W-1:0]   r_pos,  n_pos;
    logic               r_long, n_long;
    logic [VALUE_W-1:0] r_acc,  n_acc;
    logic               r_skip, n_skip;

    logic               r_out_valid;
    logic [FID_W-1:0]   r_fid,    n_fid;
    logic [VALUE_W-1:0] r_value;
    t_status            r_status, n_status;
    logic               r_done,   n_done;
    logic               n_emit;

    logic               w_lv;
    logic [VALUE_W-1:0] w_acc;
    t_loc               w_loc;
    logic               w_out_free;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign o_take     = i_stage.valid && w_out_free;

    assign w_lv  = (r_pos == '0) ? (i_stage.item.data_byte == LONG_VERSION_CODE) : r_long;
    assign w_acc = {r_acc[VALUE_W-BYTE_W-1:0], i_stage.item.data_byte};
    assign w_loc = f_locate(r_pos, w_lv);

    always_comb begin
        n_pos    = r_pos;
        n_long   = r_long;
        n_acc    = r_acc;
        n_skip   = r_skip;
        n_emit   = 1'b0;
        n_fid    = w_loc.id;
        n_status = ST_OK;
        n_done   = 1'b0;
        if (r_skip || !w_loc.hit) begin
            // past the last field: drop bytes until the box ends
            n_skip = 1'b1;
            if (!r_skip) begin
                n_long = w_lv;
                n_acc  = w_acc;
            end
            if (i_stage.item.end_of_box) begin
                n_pos = '0; n_long = 1'b0; n_acc = '0; n_skip = 1'b0;
            end
        end else if (!w_loc.last) begin
            if (i_stage.item.end_of_box) begin
                n_emit   = 1'b1;
                n_status = ST_TRUNCATED;
                n_done   = 1'b1;
                n_pos = '0; n_long = 1'b0; n_acc = '0;
            end else begin
                n_pos  = r_pos + 7'd1;
                n_long = w_lv;
                n_acc  = w_acc;
            end
        end else begin
            n_emit = 1'b1;
            if (f_is_reserved(w_loc.id) && (w_acc != '0)) begin
                n_status = ST_RSVD_NONZERO;
            end
            if ((w_loc.id == FID_NEXT_TRACK) && (w_acc == '0)) begin
                n_status = ST_NEXT_TRACK_ZERO;
            end
            if (i_stage.item.end_of_box && (w_loc.id != FID_NEXT_TRACK)) begin
                n_status = ST_TRUNCATED;
            end
            n_done = i_stage.item.end_of_box || (w_loc.id == FID_NEXT_TRACK);
            n_acc  = '0;
            if (i_stage.item.end_of_box) begin
                n_pos = '0; n_long = 1'b0;
            end else if (w_loc.id == FID_NEXT_TRACK) begin
                n_skip = 1'b1; n_pos = '0; n_long = w_lv;
            end else begin
                n_pos  = r_pos + 7'd1;
                n_long = w_lv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_long      <= 1'b0;
            r_acc       <= '0;
            r_skip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_pos  <= n_pos;
                r_long <= n_long;
                r_acc  <= n_acc;
                r_skip <= n_skip;
            end
            if (o_take && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && n_emit) begin
            r_fid    <= n_fid;
            r_value  <= w_acc;
            r_status <= n_status;
            r_done   <= n_done;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.field_id    = r_fid;
    assign o_out.field_value = r_value;
    assign o_out.status      = r_status;
    assign o_out.box_done    = r_done;

endmodule
